// ===== rtl/core/ecghr_pkg.sv =====
// Shared types and constants for the ECG smoothing and heart-rate detector.
// Used by the controller, the datapath and the top level; no dependencies.
package ecghr_pkg;

  // Smoothing window; the mean is an arithmetic shift, so keep it a power of two.
  localparam int unsigned WINDOW   = 8;
  localparam int unsigned IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SHIFT    = $clog2(WINDOW);
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = SAMPLE_W + SHIFT;

  // Rate arithmetic: 60 s/min times 16 fractional steps per bpm.
  localparam int unsigned RATE_SCALE = 960;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned NUM_W      = $clog2(RATE_SCALE * (2 ** RATE_W - 1) + 1);
  localparam int unsigned REM_W      = COUNT_W + 1;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};

  // Configuration register indexes.
  localparam logic CFG_PEAK_THRESHOLD = 1'b0;
  localparam logic CFG_SAMPLE_RATE    = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd1638;
  localparam logic [RATE_W-1:0]          RATE_HZ_RESET   = 16'd1000;

  // Output stream packing: smoothed, peak_found, rate_bpm, zero padded.
  localparam int unsigned OUT_BITS = SAMPLE_W + 1 + RATE_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the incoming sample
    logic step;        // smoothing, peak tracking and count update
    logic div_step;    // one restoring-division bit
    logic div_finish;  // saturate the quotient into the held rate
    logic emit;        // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_needed;  // this step found a peak with a nonzero count
    logic out_free;    // output register can take a new result
  } sts_t;

endpackage

// ===== rtl/core/ecghr_ctrl.sv =====
// Sequencing state machine for the ECG detector.
// Depends on ecghr_pkg for the command and status structs.
module ecghr_ctrl import ecghr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.div_needed ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/ecghr_dp.sv =====
// Datapath of the ECG detector: window ring, peak tracking, rate divider,
// configuration registers and the output register. Depends on ecghr_pkg.
module ecghr_dp import ecghr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_index_i,
  input  logic [15:0]                cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OUT_W-1:0]           out_data_o
);

  logic signed [SAMPLE_W-1:0] thresh_q;
  logic [RATE_W-1:0]          rate_hz_q;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] ring_q [WINDOW];
  logic [IDX_W-1:0]           idx_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SAMPLE_W-1:0] last_sm_q;
  logic                       last_rise_q, last_fall_q;
  logic [COUNT_W-1:0]         count_q;
  logic [RATE_W-1:0]          held_q;

  logic [NUM_W-1:0]           num_q;
  logic [COUNT_W-1:0]         den_q;
  logic [REM_W-1:0]           rem_q;

  logic signed [SAMPLE_W-1:0] sm_q;
  logic                       peak_q;
  logic                       out_valid_q;
  logic [OUT_W-1:0]           out_data_q;

  // Configuration writes are always taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= THRESHOLD_RESET;
      rate_hz_q <= RATE_HZ_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PEAK_THRESHOLD: thresh_q  <= $signed(cfg_data_i);
        CFG_SAMPLE_RATE:    rate_hz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running sum, floor mean and peak tracking.
  logic signed [SUM_W-1:0]    sum_d;
  logic signed [SUM_W-1:0]    mean_full;
  logic signed [SAMPLE_W-1:0] sm_d;
  logic                       above, rising, falling, peak;
  logic [IDX_W-1:0]           idx_d;

  assign sum_d     = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(sample_q);
  assign mean_full = sum_d >>> SHIFT;
  assign sm_d      = mean_full[SAMPLE_W-1:0];
  assign above     = sm_d > thresh_q;
  assign rising    = sm_d > last_sm_q;
  assign falling   = last_rise_q & ~rising;
  assign peak      = above & falling & ~last_fall_q;
  assign idx_d     = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;

  assign sts_o.div_needed = peak && (count_q != '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_q[k] <= '0;
      end
      idx_q       <= '0;
      sum_q       <= '0;
      last_sm_q   <= '0;
      last_rise_q <= 1'b0;
      last_fall_q <= 1'b0;
      count_q     <= '0;
    end else if (cmd_i.step) begin
      ring_q[idx_q] <= sample_q;
      idx_q         <= idx_d;
      sum_q         <= sum_d;
      if (above) begin
        last_sm_q   <= sm_d;
        last_rise_q <= rising;
        last_fall_q <= falling;
      end
      if (peak) begin
        count_q <= '0;
      end else if (count_q != COUNT_MAX) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Sample capture and per-item result staging.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.step) begin
      sm_q   <= sm_d;
      peak_q <= peak;
    end
  end

  // Restoring divider, one quotient bit per cycle; quotient builds in num_q.
  logic [REM_W-1:0] rem_shift;
  logic             q_bit;

  assign rem_shift = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign q_bit     = rem_shift >= REM_W'(den_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      num_q <= NUM_W'(RATE_SCALE) * NUM_W'(rate_hz_q);
      den_q <= count_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_shift - REM_W'(den_q) : rem_shift;
      num_q <= {num_q[NUM_W-2:0], q_bit};
    end
  end

  // Held rate saturates at the top of its range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.div_finish) begin
      held_q <= (num_q > NUM_W'(RATE_MAX)) ? RATE_MAX : num_q[RATE_W-1:0];
    end
  end

  // Output register holds a result until the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= OUT_W'({held_q, peak_q, sm_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/ecg_smoothing_heart_rate_detector_core.sv =====
// A sample transaction loads the sample in IDLE; CALC then smooths it, tracks peaks and
// updates the count. A sample that completes a peak with a nonzero count then runs
// through the bit-serial restoring divider (DIV, then FIN) before EMIT loads the output
// register; EMIT waits while that register is full. No new sample is taken until then.
// A result waiting in the output register does not block the next sample's work.
// Reset (rst_ni, asynchronous, active low) clears the window ring, sum, tracking
// flags, count and held rate, and loads threshold 1638 and sample rate 1000.
module ecg_smoothing_heart_rate_detector_core import ecghr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] sample
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [15:0] smoothed, [16] peak_found,
                                            // [32:17] rate_bpm, rest zero
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ecghr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecghr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    ($signed(s_axis_tdata)),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== bench/ecg_smoothing_heart_rate_detector_core_tb.sv =====
// Self-checking testbench for ecg_smoothing_heart_rate_detector_core.
// It predicts each result with its own moving-average and peak tracker, except typed rows.
// It depends only on the RTL and ecghr_pkg.
`timescale 1ns / 100ps

module ecg_smoothing_heart_rate_detector_core_tb;
  import ecghr_pkg::*;

  localparam int unsigned BPM_SCALE_X16  = 960;   // 60 s/min times 16 steps per bpm
  localparam int unsigned STALL_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DIR_ROWS       = 20;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 130;
  localparam int unsigned DRAIN_CYCLES   = 40;

  // One result, field by field.
  typedef struct packed {
    logic signed [15:0] mean;
    logic               peak;
    logic [15:0]        bpm;
  } detector_out_t;

  // One directed sample; typed rows carry their expected result.
  typedef struct packed {
    logic [15:0]   sample;
    logic          typed;
    detector_out_t want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_PEAK_THRESHOLD;
  logic [15:0]       cfg_data_i = '0;

  // Tracker state of the predictor.
  logic signed [15:0] ring_q [8];
  logic [2:0]         wr_pos;
  logic signed [18:0] win_sum;
  logic signed [15:0] prev_mean;
  logic               prev_up;
  logic               prev_down;
  logic [23:0]        beat_gap;
  logic [15:0]        bpm_hold;
  logic signed [15:0] level_thresh;
  logic [15:0]        rate_hz;

  // Pulse-train generator state.
  int                 beat_pos = 0;
  int                 beat_len = 1;
  int                 beat_amp = 0;

  detector_out_t      filtered_q [$];
  int unsigned        mismatch_count = 0;
  bit                 idle_on = 1'b1;
  bit                 hold_req = 1'b0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{16'h0000, 1'b1, '{16'sh0000, 1'b0, 16'h0000}},
    '{16'h8000, 1'b1, '{16'shF000, 1'b0, 16'h0000}},
    '{16'h7FFF, 1'b1, '{16'shFFFF, 1'b0, 16'h0000}},
    '{16'h0001, 1'b1, '{16'sh0000, 1'b0, 16'h0000}},
    '{16'h7FFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h4000, 1'b0, '0},
    '{16'h6000, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h2000, 1'b0, '0},
    '{16'h0000, 1'b0, '0}
  };

  ecg_smoothing_heart_rate_detector_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bring the tracker to its power-up state.
  task automatic clear_tracker();
    for (int k = 0; k < 8; k++) ring_q[k] = '0;
    wr_pos       = '0;
    win_sum      = '0;
    prev_mean    = '0;
    prev_up      = 1'b0;
    prev_down    = 1'b0;
    beat_gap     = '0;
    bpm_hold     = '0;
    level_thresh = 16'sd1638;
    rate_hz      = 16'd1000;
  endtask

  // Smooth one sample and run the peak and rate tracking on it.
  function automatic detector_out_t smooth_and_track(logic [15:0] x);
    logic signed [18:0] nsum;
    logic signed [15:0] mean;
    logic               up;
    logic               down;
    logic               hit;
    logic [31:0]        quot;
    detector_out_t      o;
    hit  = 1'b0;
    nsum = win_sum - {{3{ring_q[wr_pos][15]}}, ring_q[wr_pos]} + {{3{x[15]}}, x};
    win_sum        = nsum;
    ring_q[wr_pos] = x;
    wr_pos         = wr_pos + 3'd1;
    // Dropping the low three bits of the sum floors the mean.
    mean = nsum[18:3];
    if (mean > level_thresh) begin
      up   = mean > prev_mean;
      down = prev_up && !up;
      if (down && !prev_down) begin
        hit = 1'b1;
        if (beat_gap != '0) begin
          quot     = (32'(BPM_SCALE_X16) * {16'b0, rate_hz}) / {8'b0, beat_gap};
          bpm_hold = (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
        end
        beat_gap = '0;
      end else if (beat_gap != '1) begin
        beat_gap = beat_gap + 24'd1;
      end
      prev_mean = mean;
      prev_up   = up;
      prev_down = down;
    end else if (beat_gap != '1) begin
      beat_gap = beat_gap + 24'd1;
    end
    o.mean = mean;
    o.peak = hit;
    o.bpm  = bpm_hold;
    return o;
  endfunction

  // Mostly pulse trains with random shape, plus noise and field extremes.
  function automatic logic [15:0] next_ecg_sample();
    int          pick;
    logic [15:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      v = 16'($urandom);
    end else if (pick < 12) begin
      case ($urandom_range(0, 3))
        0:       v = 16'h8000;
        1:       v = 16'h7FFF;
        2:       v = 16'h0000;
        default: v = 16'hFFFF;
      endcase
    end else begin
      if (beat_pos == 0) begin
        beat_len = $urandom_range(3, 48);
        beat_amp = $urandom_range(6000, 32767);
      end
      if (beat_pos < 3) v = 16'(beat_amp - int'($urandom_range(0, 2000)));
      else v = 16'(int'($urandom_range(0, 4000)) - 2000);
      beat_pos = (beat_pos + 1 >= beat_len) ? 0 : beat_pos + 1;
    end
    return v;
  endfunction

  // Offer one sample and record its expected result on the transaction.
  task automatic send_sample(input logic [15:0] v, input logic typed,
                             input detector_out_t typed_out);
    detector_out_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = smooth_and_track(v);
    if (typed) want = typed_out;
    filtered_q.push_back(want);
  endtask

  // Write one register; only called while the block is idle. The caller
  // lowers cfg_valid_i once its writes are done.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_PEAK_THRESHOLD) level_thresh = val;
    else rate_hz = val;
  endtask

  task automatic wait_drained();
    while (filtered_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check each transaction, then pick the next ready value.
  initial begin
    int unsigned   stall_left;
    detector_out_t want;
    logic [OUT_W-1:0] got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = filtered_q.pop_front();
          if (got[15:0] !== want.mean) begin
            $display("%0t: smoothed expected %h actual %h", $time, want.mean, got[15:0]);
            mismatch_count++;
          end
          if (got[16] !== want.peak) begin
            $display("%0t: peak_found expected %b actual %b", $time, want.peak, got[16]);
            mismatch_count++;
          end
          if (got[32:17] !== want.bpm) begin
            $display("%0t: rate_bpm expected %h actual %h", $time, want.bpm, got[32:17]);
            mismatch_count++;
          end
          if (got[OUT_W-1:33] !== '0) begin
            $display("%0t: padding expected 0 actual %h", $time, got[OUT_W-1:33]);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        // Long hold-off so the block fills up and stalls its input.
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("ecg_smoothing_heart_rate_detector_core regression: fail");
    $finish;
  end

  // Main sequence: reset, directed samples, then random phases.
  initial begin
    logic [15:0] thr;
    logic [15:0] hz;
    clear_tracker();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_sample(directed_rows[r].sample, directed_rows[r].typed, directed_rows[r].want);
    end
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin thr = 16'h8000; hz = 16'd1;     end  // lowest threshold, slowest nonzero rate
        1: begin thr = 16'h7FFF; hz = 16'd65535; end  // nothing can pass the threshold
        2: begin thr = 16'd800;  hz = 16'd0;     end  // zero rate
        default: begin
          thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
          hz  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(100, 2000));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_PEAK_THRESHOLD, thr);
        write_reg(CFG_SAMPLE_RATE, hz);
      end else begin
        write_reg(CFG_SAMPLE_RATE, hz);
        write_reg(CFG_PEAK_THRESHOLD, thr);
      end
      cfg_valid_i <= 1'b0;
      if (p == PHASES - 1) idle_on = 1'b0;
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(next_ecg_sample(), 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ecg_smoothing_heart_rate_detector_core regression: pass");
    end else begin
      $display("ecg_smoothing_heart_rate_detector_core regression: fail");
    end
    $finish;
  end

endmodule
